// ===== sv/bdg_pkg.sv =====
`timescale 1ns / 1ps

package bdg_pkg;

  // Queue depth between the classifier and the rectangle sequencer.
  localparam int unsigned BDG_QUEUE_DEPTH = 2;

  // Width of a signed offset from the cell base, and of a summed coordinate.
  localparam int unsigned OFF_W = 10;
  localparam int unsigned SUM_W = 17;

  // Saturation limits of the output coordinates.
  localparam logic signed [SUM_W-1:0] COORD_MIN = -17'sd128;
  localparam logic signed [SUM_W-1:0] COORD_MAX = 17'sd32767;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CELL_WIDTH     = 2'd0,
    REG_CELL_HEIGHT    = 2'd1,
    REG_LINE_THICKNESS = 2'd2
  } reg_index_e;

  // Position codes: x positions first, y positions from code 8 on.
  localparam logic [3:0] PL  = 4'd0;
  localparam logic [3:0] PR  = 4'd1;
  localparam logic [3:0] XM  = 4'd2;
  localparam logic [3:0] X1  = 4'd3;
  localparam logic [3:0] X2  = 4'd4;
  localparam logic [3:0] XMT = 4'd5;
  localparam logic [3:0] X1T = 4'd6;
  localparam logic [3:0] X2T = 4'd7;
  localparam logic [3:0] PT  = 4'd8;
  localparam logic [3:0] PB  = 4'd9;
  localparam logic [3:0] YM  = 4'd10;
  localparam logic [3:0] Y1  = 4'd11;
  localparam logic [3:0] Y2  = 4'd12;
  localparam logic [3:0] YMT = 4'd13;
  localparam logic [3:0] Y1T = 4'd14;
  localparam logic [3:0] Y2T = 4'd15;

  typedef struct packed {
    logic [6:0] cell_width;
    logic [7:0] cell_height;
    logic [4:0] line_thickness;
  } cfg_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [7:0]  cell_column;
    logic [13:0] row_top;
  } req_t;

  typedef struct packed {
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic               glyph_known;
    logic               smoothable;
    logic               last_rect;
  } rsp_t;

  // Rectangle list of one glyph: four corner codes per rectangle.
  typedef struct packed {
    logic              known;
    logic [2:0]        last_idx;
    logic [0:7][15:0]  codes;
  } glyph_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    glyph_t      glyph;
    logic [14:0] col_base;
    logic [13:0] row_base;
  } entry_t;

  function automatic logic [15:0] rc(input logic [3:0] l, input logic [3:0] t,
                                     input logic [3:0] r, input logic [3:0] b);
    return {l, t, r, b};
  endfunction

  function automatic glyph_t mk(input logic [3:0] n, input logic [15:0] c0,
                                input logic [15:0] c1 = 16'h0,
                                input logic [15:0] c2 = 16'h0,
                                input logic [15:0] c3 = 16'h0,
                                input logic [15:0] c4 = 16'h0,
                                input logic [15:0] c5 = 16'h0,
                                input logic [15:0] c6 = 16'h0,
                                input logic [15:0] c7 = 16'h0);
    glyph_t g;
    g.known    = 1'b1;
    g.last_idx = 3'(n - 4'd1);
    g.codes    = {c0, c1, c2, c3, c4, c5, c6, c7};
    return g;
  endfunction

  // Map a code point to its rectangle list; unknown points give one empty entry.
  function automatic glyph_t glyph_lookup(input logic [20:0] cp);
    glyph_t g;
    g = '0;
    case (cp)
      21'h02500: g = mk(4'd1, rc(PL,YM,PR,YMT));
      21'h02502: g = mk(4'd1, rc(XM,PT,XMT,PB));
      21'h0250C: g = mk(4'd2, rc(XM,YM,PR,YMT), rc(XM,YM,XMT,PB));
      21'h02510: g = mk(4'd2, rc(PL,YM,XM,YMT), rc(XM,YM,XMT,PB));
      21'h02514: g = mk(4'd2, rc(XM,YM,PR,YMT), rc(XM,PT,XMT,YM));
      21'h02518: g = mk(4'd2, rc(PL,YM,XMT,YMT), rc(XM,PT,XMT,YM));
      21'h0251C: g = mk(4'd2, rc(XM,YM,PR,YMT), rc(XM,PT,XMT,PB));
      21'h02524: g = mk(4'd2, rc(PL,YM,XM,YMT), rc(XM,PT,XMT,PB));
      21'h0252C: g = mk(4'd2, rc(PL,YM,PR,YMT), rc(XM,YM,XMT,PB));
      21'h02534: g = mk(4'd2, rc(PL,YM,PR,YMT), rc(XM,PT,XMT,YM));
      21'h0253C: g = mk(4'd2, rc(PL,YM,PR,YMT), rc(XM,PT,XMT,PB));
      21'h02550: g = mk(4'd2, rc(PL,Y1,PR,Y1T), rc(PL,Y2,PR,Y2T));
      21'h02551: g = mk(4'd2, rc(X1,PT,X1T,PB), rc(X2,PT,X2T,PB));
      21'h02552: g = mk(4'd3, rc(XM,Y1,PR,Y1T), rc(XM,Y2,PR,Y2T), rc(XM,Y1,XMT,PB));
      21'h02553: g = mk(4'd3, rc(X1,YM,PR,YMT), rc(X1,YM,X1T,PB), rc(X2,YM,X2T,PB));
      21'h02554: g = mk(4'd4, rc(X1,Y1,PR,Y1T), rc(X2,Y2,PR,Y2T), rc(X1,Y1,X1T,PB),
                        rc(X2,Y2,X2T,PB));
      21'h02555: g = mk(4'd3, rc(PL,Y1,XMT,Y1T), rc(PL,Y2,XM,Y2T), rc(XM,Y1,XMT,PB));
      21'h02556: g = mk(4'd3, rc(PL,YM,X2,YMT), rc(X1,YM,X1T,PB), rc(X2,YM,X2T,PB));
      21'h02557: g = mk(4'd4, rc(PL,Y1,X2,Y1T), rc(PL,Y2,X1,Y2T), rc(X2,Y1,X2T,PB),
                        rc(X1,Y2,X1T,PB));
      21'h02558: g = mk(4'd3, rc(XM,Y1,PR,Y1T), rc(XM,Y2,PR,Y2T), rc(XM,PT,XMT,Y2));
      21'h02559: g = mk(4'd3, rc(X1,YM,PR,YMT), rc(X1,PT,X1T,YM), rc(X2,PT,X2T,YM));
      21'h0255A: g = mk(4'd4, rc(X2,Y1,PR,Y1T), rc(X1,Y2,PR,Y2T), rc(X1,PT,X1T,Y2),
                        rc(X2,PT,X2T,Y1));
      21'h0255B: g = mk(4'd3, rc(PL,Y1,XM,Y1T), rc(PL,Y2,XM,Y2T), rc(XM,PT,XMT,Y2T));
      21'h0255C: g = mk(4'd3, rc(PL,YM,X2T,YMT), rc(X1,PT,X1T,YM), rc(X2,PT,X2T,YM));
      21'h0255D: g = mk(4'd4, rc(PL,Y1,X1T,Y1T), rc(PL,Y2,X2T,Y2T), rc(X1,PT,X1T,Y1),
                        rc(X2,PT,X2T,Y2));
      21'h0255E: g = mk(4'd4, rc(XM,Y1,PR,Y1T), rc(XM,Y2,PR,Y2T), rc(XM,PT,XMT,Y1),
                        rc(XM,Y2,XMT,PB));
      21'h0255F: g = mk(4'd3, rc(X2,YM,PR,YMT), rc(X1,PT,X1T,PB), rc(X2,PT,X2T,PB));
      21'h02560: g = mk(4'd5, rc(X2,Y1,PR,Y1T), rc(X2,Y2,PR,Y2T), rc(X1,PT,X1T,PB),
                        rc(X2,PT,X2T,Y1), rc(X2,Y2,X2T,PB));
      21'h02561: g = mk(4'd4, rc(PL,Y1,XMT,Y1T), rc(PL,Y2,XM,Y2T), rc(XM,PT,XMT,Y1),
                        rc(XM,Y2,XMT,PB));
      21'h02562: g = mk(4'd3, rc(PL,YM,X1,YMT), rc(X1,PT,X1T,PB), rc(X2,PT,X2T,PB));
      21'h02563: g = mk(4'd5, rc(PL,Y1,X1T,Y1T), rc(PL,Y2,X1,Y2T), rc(X1,PT,X1T,Y1),
                        rc(X1,Y2,X1T,PB), rc(X2,PT,X2T,PB));
      21'h02564: g = mk(4'd3, rc(PL,Y1,PR,Y1T), rc(PL,Y2,PR,Y2T), rc(XM,Y2,XMT,PB));
      21'h02565: g = mk(4'd3, rc(PL,YM,PR,YMT), rc(X1,YM,X1T,PB), rc(X2,YM,X2T,PB));
      21'h02566: g = mk(4'd5, rc(PL,Y1,PR,Y1T), rc(PL,Y2,X1,Y2T), rc(X2,Y2,PR,Y2T),
                        rc(X1,Y2,X1T,PB), rc(X2,Y2,X2T,PB));
      21'h02567: g = mk(4'd3, rc(PL,Y1,PR,Y1T), rc(PL,Y2,PR,Y2T), rc(XM,PT,XMT,Y1));
      21'h02568: g = mk(4'd3, rc(PL,YM,PR,YMT), rc(X1,PT,X1T,YM), rc(X2,PT,X2T,YM));
      21'h02569: g = mk(4'd5, rc(PL,Y1,X1T,Y1T), rc(X2,Y1,PR,Y1T), rc(PL,Y2,PR,Y2T),
                        rc(X1,PT,X1T,Y1), rc(X2,PT,X2T,Y1));
      21'h0256A: g = mk(4'd3, rc(PL,Y1,PR,Y1T), rc(PL,Y2,PR,Y2T), rc(XM,PT,XMT,PB));
      21'h0256B: g = mk(4'd3, rc(PL,YM,PR,YMT), rc(X1,PT,X1T,PB), rc(X2,PT,X2T,PB));
      21'h0256C: g = mk(4'd8, rc(PL,Y1,X1T,Y1T), rc(X2,Y1,PR,Y1T), rc(PL,Y2,X1,Y2T),
                        rc(X2,Y2,PR,Y2T), rc(X1,PT,X1T,Y1), rc(X1,Y2,X1T,PB),
                        rc(X2,PT,X2T,Y1), rc(X2,Y2,X2T,PB));
      default:   g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/bdg_front.sv =====
`timescale 1ns / 1ps

module bdg_front import bdg_pkg::*; (
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  req_t   in_req_i,
  input  cfg_t   cfg_i,
  input  logic   queue_full_i,
  output logic   push_o,
  output entry_t entry_o
);

  // A request is taken whenever the queue has room.
  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Classify the code point and work out the cell's left edge.
  always_comb begin
    entry_o.glyph    = glyph_lookup(in_req_i.code_point);
    entry_o.col_base = 15'(in_req_i.cell_column) * 15'(cfg_i.cell_width);
    entry_o.row_base = in_req_i.row_top;
  end

endmodule

// ===== sv/bdg_queue.sv =====
`timescale 1ns / 1ps

module bdg_queue import bdg_pkg::*; #(
  parameter int unsigned DEPTH = BDG_QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/bdg_back.sv =====
`timescale 1ns / 1ps

module bdg_back import bdg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   queue_empty_i,
  input  entry_t entry_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output rsp_t   out_rsp_o
);

  logic                    busy_q, busy_d;
  logic [2:0]              k_q, k_d;
  entry_t                  ent_q;
  logic                    out_valid_q, out_valid_d;
  rsp_t                    out_q;
  rsp_t                    rect;
  logic                    advance;
  logic                    last;
  logic                    fin;
  logic                    load;
  logic [15:0]             code;
  logic signed [OFF_W-1:0] w_s, h_s, t_s, d_s, tm1_s;
  logic signed [OFF_W-1:0] xm_s, ym_s, x1_s, x2_s, y1_s, y2_s;
  logic signed [OFF_W-1:0] off [16];
  logic [7:0]              min_hw;

  // Offsets of every position from the cell's left or top edge.
  always_comb begin
    w_s    = signed'(OFF_W'(cfg_i.cell_width));
    h_s    = signed'(OFF_W'(cfg_i.cell_height));
    t_s    = signed'(OFF_W'(cfg_i.line_thickness));
    min_hw = (cfg_i.cell_height < {1'b0, cfg_i.cell_width})
             ? cfg_i.cell_height : {1'b0, cfg_i.cell_width};
    d_s    = signed'(OFF_W'(min_hw[7:2]));
    tm1_s  = t_s - OFF_W'(1);
    xm_s   = (w_s >>> 1) - (t_s >>> 1);
    ym_s   = (h_s >>> 1) - (t_s >>> 1);
    x1_s   = xm_s - d_s;
    x2_s   = xm_s + d_s;
    y1_s   = ym_s - d_s;
    y2_s   = ym_s + d_s;
    off[PL]  = '0;
    off[PR]  = w_s - OFF_W'(1);
    off[XM]  = xm_s;
    off[X1]  = x1_s;
    off[X2]  = x2_s;
    off[XMT] = xm_s + tm1_s;
    off[X1T] = x1_s + tm1_s;
    off[X2T] = x2_s + tm1_s;
    off[PT]  = '0;
    off[PB]  = h_s - OFF_W'(1);
    off[YM]  = ym_s;
    off[Y1]  = y1_s;
    off[Y2]  = y2_s;
    off[YMT] = ym_s + tm1_s;
    off[Y1T] = y1_s + tm1_s;
    off[Y2T] = y2_s + tm1_s;
  end

  // One corner: cell base plus offset, saturated to the output range.
  function automatic logic signed [15:0] corner(input logic [3:0] pc,
                                                input logic [14:0] col_base,
                                                input logic [13:0] row_base,
                                                input logic signed [OFF_W-1:0] o);
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] sum;
    base = pc[3] ? signed'(SUM_W'(row_base)) : signed'(SUM_W'(col_base));
    sum  = base + SUM_W'(o);
    if (sum < COORD_MIN) begin
      return COORD_MIN[15:0];
    end else if (sum > COORD_MAX) begin
      return COORD_MAX[15:0];
    end
    return sum[15:0];
  endfunction

  // Rectangle for the current step of the working entry.
  always_comb begin
    code = ent_q.glyph.codes[k_q];
    last = (k_q == ent_q.glyph.last_idx);
    rect.smoothable = 1'b1;
    if (ent_q.glyph.known) begin
      rect.rect_left   = corner(code[15:12], ent_q.col_base, ent_q.row_base,
                                off[code[15:12]]);
      rect.rect_top    = corner(code[11:8], ent_q.col_base, ent_q.row_base,
                                off[code[11:8]]);
      rect.rect_right  = corner(code[7:4], ent_q.col_base, ent_q.row_base,
                                off[code[7:4]]);
      rect.rect_bottom = corner(code[3:0], ent_q.col_base, ent_q.row_base,
                                off[code[3:0]]);
      rect.glyph_known = 1'b1;
      rect.last_rect   = last;
    end else begin
      rect.rect_left   = '0;
      rect.rect_top    = '0;
      rect.rect_right  = '0;
      rect.rect_bottom = '0;
      rect.glyph_known = 1'b0;
      rect.last_rect   = 1'b1;
    end
  end

  // Sequencing: one rectangle per cycle while the output register can move.
  always_comb begin
    advance     = !out_valid_q || out_ready_i;
    fin         = busy_q && advance && (last || !ent_q.glyph.known);
    load        = !queue_empty_i && (!busy_q || fin);
    busy_d      = busy_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q && advance) begin
      k_d = k_q + 1'b1;
    end
    if (busy_q && advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pop_o       = load;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working entry and output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= entry_i;
    end
    if (busy_q && advance) begin
      out_q <= rect;
    end
  end

endmodule

// ===== sv/box_drawing_glyph_rectangles_top.sv =====
`timescale 1ns / 1ps
// The first rectangle of a glyph passes through the queue, the working entry and the output register.
// Throughput: one rectangle per cycle while the output is not stalled; a glyph gives 1 to 8
// rectangles (an unknown code point gives 1).
// Requests are taken while the classifier queue has room, also during output stalls.
// Reset clears the queue and sequencer and loads width 8, height 16, thickness 1.
module box_drawing_glyph_rectangles_top import bdg_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = BDG_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o
);

  cfg_t   cfg_q;
  logic   queue_full;
  logic   queue_empty;
  logic   push;
  logic   pop;
  entry_t entry_in;
  entry_t entry_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_width     <= 7'd8;
      cfg_q.cell_height    <= 8'd16;
      cfg_q.line_thickness <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CELL_WIDTH:     cfg_q.cell_width     <= cfg_data_i[6:0];
        REG_CELL_HEIGHT:    cfg_q.cell_height    <= cfg_data_i;
        REG_LINE_THICKNESS: cfg_q.line_thickness <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify requests.
  bdg_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (entry_in)
  );

  // Queue between front and back.
  bdg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .entry_o (entry_out)
  );

  // Back: emit rectangles one per cycle while the output can move.
  bdg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (queue_empty),
    .entry_i       (entry_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_o     (out_rsp_o)
  );

endmodule

// ===== sim/glyph_rect_checker.sv =====
`timescale 1ns / 1ps

module glyph_rect_checker import bdg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned rects_pending_o
);

  // Shadow copy of the cell geometry registers.
  logic [6:0] cell_w;
  logic [7:0] cell_h;
  logic [4:0] stroke;

  // Rectangles predicted for accepted requests, oldest first.
  rsp_t        rects_due [$];
  int unsigned rects_seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on rectangle %0d: %s", $time, rects_seen, what);
    mismatch_count_o++;
  endtask

  // Corner codes of each supported glyph, first rectangle in the upper bits.
  // The top corner of every rectangle is a y code, so no code word is zero.
  function automatic logic [127:0] glyph_corners(input logic [20:0] cp);
    logic [127:0] shape;
    shape = '0;
    case (cp)
      21'h02500: shape = {PL,YM,PR,YMT};
      21'h02502: shape = {XM,PT,XMT,PB};
      21'h0250C: shape = {XM,YM,PR,YMT, XM,YM,XMT,PB};
      21'h02510: shape = {PL,YM,XM,YMT, XM,YM,XMT,PB};
      21'h02514: shape = {XM,YM,PR,YMT, XM,PT,XMT,YM};
      21'h02518: shape = {PL,YM,XMT,YMT, XM,PT,XMT,YM};
      21'h0251C: shape = {XM,YM,PR,YMT, XM,PT,XMT,PB};
      21'h02524: shape = {PL,YM,XM,YMT, XM,PT,XMT,PB};
      21'h0252C: shape = {PL,YM,PR,YMT, XM,YM,XMT,PB};
      21'h02534: shape = {PL,YM,PR,YMT, XM,PT,XMT,YM};
      21'h0253C: shape = {PL,YM,PR,YMT, XM,PT,XMT,PB};
      21'h02550: shape = {PL,Y1,PR,Y1T, PL,Y2,PR,Y2T};
      21'h02551: shape = {X1,PT,X1T,PB, X2,PT,X2T,PB};
      21'h02552: shape = {XM,Y1,PR,Y1T, XM,Y2,PR,Y2T, XM,Y1,XMT,PB};
      21'h02553: shape = {X1,YM,PR,YMT, X1,YM,X1T,PB, X2,YM,X2T,PB};
      21'h02554: shape = {X1,Y1,PR,Y1T, X2,Y2,PR,Y2T, X1,Y1,X1T,PB, X2,Y2,X2T,PB};
      21'h02555: shape = {PL,Y1,XMT,Y1T, PL,Y2,XM,Y2T, XM,Y1,XMT,PB};
      21'h02556: shape = {PL,YM,X2,YMT, X1,YM,X1T,PB, X2,YM,X2T,PB};
      21'h02557: shape = {PL,Y1,X2,Y1T, PL,Y2,X1,Y2T, X2,Y1,X2T,PB, X1,Y2,X1T,PB};
      21'h02558: shape = {XM,Y1,PR,Y1T, XM,Y2,PR,Y2T, XM,PT,XMT,Y2};
      21'h02559: shape = {X1,YM,PR,YMT, X1,PT,X1T,YM, X2,PT,X2T,YM};
      21'h0255A: shape = {X2,Y1,PR,Y1T, X1,Y2,PR,Y2T, X1,PT,X1T,Y2, X2,PT,X2T,Y1};
      21'h0255B: shape = {PL,Y1,XM,Y1T, PL,Y2,XM,Y2T, XM,PT,XMT,Y2T};
      21'h0255C: shape = {PL,YM,X2T,YMT, X1,PT,X1T,YM, X2,PT,X2T,YM};
      21'h0255D: shape = {PL,Y1,X1T,Y1T, PL,Y2,X2T,Y2T, X1,PT,X1T,Y1, X2,PT,X2T,Y2};
      21'h0255E: shape = {XM,Y1,PR,Y1T, XM,Y2,PR,Y2T, XM,PT,XMT,Y1, XM,Y2,XMT,PB};
      21'h0255F: shape = {X2,YM,PR,YMT, X1,PT,X1T,PB, X2,PT,X2T,PB};
      21'h02560: shape = {X2,Y1,PR,Y1T, X2,Y2,PR,Y2T, X1,PT,X1T,PB, X2,PT,X2T,Y1,
                          X2,Y2,X2T,PB};
      21'h02561: shape = {PL,Y1,XMT,Y1T, PL,Y2,XM,Y2T, XM,PT,XMT,Y1, XM,Y2,XMT,PB};
      21'h02562: shape = {PL,YM,X1,YMT, X1,PT,X1T,PB, X2,PT,X2T,PB};
      21'h02563: shape = {PL,Y1,X1T,Y1T, PL,Y2,X1,Y2T, X1,PT,X1T,Y1, X1,Y2,X1T,PB,
                          X2,PT,X2T,PB};
      21'h02564: shape = {PL,Y1,PR,Y1T, PL,Y2,PR,Y2T, XM,Y2,XMT,PB};
      21'h02565: shape = {PL,YM,PR,YMT, X1,YM,X1T,PB, X2,YM,X2T,PB};
      21'h02566: shape = {PL,Y1,PR,Y1T, PL,Y2,X1,Y2T, X2,Y2,PR,Y2T, X1,Y2,X1T,PB,
                          X2,Y2,X2T,PB};
      21'h02567: shape = {PL,Y1,PR,Y1T, PL,Y2,PR,Y2T, XM,PT,XMT,Y1};
      21'h02568: shape = {PL,YM,PR,YMT, X1,PT,X1T,YM, X2,PT,X2T,YM};
      21'h02569: shape = {PL,Y1,X1T,Y1T, X2,Y1,PR,Y1T, PL,Y2,PR,Y2T, X1,PT,X1T,Y1,
                          X2,PT,X2T,Y1};
      21'h0256A: shape = {PL,Y1,PR,Y1T, PL,Y2,PR,Y2T, XM,PT,XMT,PB};
      21'h0256B: shape = {PL,YM,PR,YMT, X1,PT,X1T,PB, X2,PT,X2T,PB};
      21'h0256C: shape = {PL,Y1,X1T,Y1T, X2,Y1,PR,Y1T, PL,Y2,X1,Y2T, X2,Y2,PR,Y2T,
                          X1,PT,X1T,Y1, X1,Y2,X1T,PB, X2,PT,X2T,Y1, X2,Y2,X2T,PB};
      default:   shape = '0;
    endcase
    return shape;
  endfunction

  function automatic logic signed [15:0] clamp_coord(input int v);
    if (v < COORD_MIN) return 16'(COORD_MIN);
    if (v > COORD_MAX) return 16'(COORD_MAX);
    return 16'(v);
  endfunction

  // Work out every rectangle of one request and queue them in order.
  task automatic predict_glyph_rects(input req_t req);
    logic [127:0] shape;
    logic [15:0]  corners;
    int           count, k, w, h, t, d;
    int           pos [16];
    rsp_t         rect;
    shape = glyph_corners(req.code_point);
    count = 0;
    for (k = 0; k < 8; k++) begin
      if (shape[16*k +: 16] != '0) count = k + 1;
    end
    rect = '0;
    rect.smoothable = 1'b1;
    if (count == 0) begin
      // Unsupported code point: a single empty rectangle, marked unknown.
      rect.last_rect = 1'b1;
      rects_due.push_back(rect);
    end else begin
      w = int'(cell_w);
      h = int'(cell_h);
      t = int'(stroke);
      d = ((h < w) ? h : w) / 4;
      pos[PL]  = int'(req.cell_column) * w;
      pos[PR]  = pos[PL] + w - 1;
      pos[XM]  = pos[PL] + w / 2 - t / 2;
      pos[X1]  = pos[XM] - d;
      pos[X2]  = pos[XM] + d;
      pos[XMT] = pos[XM] + t - 1;
      pos[X1T] = pos[X1] + t - 1;
      pos[X2T] = pos[X2] + t - 1;
      pos[PT]  = int'(req.row_top);
      pos[PB]  = pos[PT] + h - 1;
      pos[YM]  = pos[PT] + h / 2 - t / 2;
      pos[Y1]  = pos[YM] - d;
      pos[Y2]  = pos[YM] + d;
      pos[YMT] = pos[YM] + t - 1;
      pos[Y1T] = pos[Y1] + t - 1;
      pos[Y2T] = pos[Y2] + t - 1;
      rect.glyph_known = 1'b1;
      for (k = 0; k < count; k++) begin
        corners          = shape[16*(count-1-k) +: 16];
        rect.rect_left   = clamp_coord(pos[corners[15:12]]);
        rect.rect_top    = clamp_coord(pos[corners[11:8]]);
        rect.rect_right  = clamp_coord(pos[corners[7:4]]);
        rect.rect_bottom = clamp_coord(pos[corners[3:0]]);
        rect.last_rect   = (k == count - 1);
        rects_due.push_back(rect);
      end
    end
  endtask

  task automatic compare_rect(input rsp_t got, input rsp_t want);
    if (got.rect_left !== want.rect_left)
      report_mismatch($sformatf("rect_left %0d, expected %0d", got.rect_left, want.rect_left));
    if (got.rect_top !== want.rect_top)
      report_mismatch($sformatf("rect_top %0d, expected %0d", got.rect_top, want.rect_top));
    if (got.rect_right !== want.rect_right)
      report_mismatch($sformatf("rect_right %0d, expected %0d", got.rect_right,
                                want.rect_right));
    if (got.rect_bottom !== want.rect_bottom)
      report_mismatch($sformatf("rect_bottom %0d, expected %0d", got.rect_bottom,
                                want.rect_bottom));
    if (got.glyph_known !== want.glyph_known)
      report_mismatch($sformatf("glyph_known %b, expected %b", got.glyph_known,
                                want.glyph_known));
    if (got.smoothable !== want.smoothable)
      report_mismatch($sformatf("smoothable %b, expected %b", got.smoothable,
                                want.smoothable));
    if (got.last_rect !== want.last_rect)
      report_mismatch($sformatf("last_rect %b, expected %b", got.last_rect, want.last_rect));
  endtask

  // Follow register writes, predict on each request, check each rectangle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w = 7'd8;
      cell_h = 8'd16;
      stroke = 5'd1;
      rects_due.delete();
      rects_seen = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CELL_WIDTH:     cell_w = cfg_data_i[6:0];
          REG_CELL_HEIGHT:    cell_h = cfg_data_i;
          REG_LINE_THICKNESS: stroke = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_glyph_rects(in_req_i);
      if (out_valid_i && out_ready_i) begin
        if (rects_due.size() == 0) begin
          report_mismatch("rectangle arrived with none expected");
        end else begin
          compare_rect(out_rsp_i, rects_due.pop_front());
        end
        rects_seen++;
      end
    end
    rects_pending_o = rects_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench import bdg_pkg::*;;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [20:0] BOX_FIRST    = 21'h02500;
  localparam logic [20:0] DOUBLE_FIRST = 21'h02550;

  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int HOLD_CYCLES     = 40;
  localparam int SETTLE_CYCLES   = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  req_t       in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rsp_t       out_rsp_o;

  int unsigned mismatch_total;
  int unsigned rects_pending;

  // Set by the request side to ask the sink for one long stall.
  bit hold_output = 1'b0;
  // Set by the sink once that long stall is over.
  bit hold_done = 1'b0;
  // No idling on either side once this is set.
  bit calm = 1'b0;

  box_drawing_glyph_rectangles_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  glyph_rect_checker rect_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_req_i         (in_req_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_rsp_i        (out_rsp_o),
    .mismatch_count_o (mismatch_total),
    .rects_pending_o  (rects_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL box_drawing_glyph_rectangles_top");
    $finish;
  end

  // Rectangle sink: random short stalls, plus one long stall on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 2)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic offer_glyph(input logic [20:0] cp, input logic [7:0] col,
                             input logic [13:0] row, input bit allow_gap);
    req_t req;
    req.code_point  = cp;
    req.cell_column = col;
    req.row_top     = row;
    if (allow_gap && !calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [20:0] single_line_glyph(input int k);
    case (k)
      0:       return 21'h02500;
      1:       return 21'h02502;
      2:       return 21'h0250C;
      3:       return 21'h02510;
      4:       return 21'h02514;
      5:       return 21'h02518;
      6:       return 21'h0251C;
      7:       return 21'h02524;
      8:       return 21'h0252C;
      9:       return 21'h02534;
      default: return 21'h0253C;
    endcase
  endfunction

  // Mostly supported glyphs, some neighbors in the block and some noise.
  task automatic offer_random_glyph(input bit allow_gap);
    logic [20:0] cp;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) cp = DOUBLE_FIRST + 21'($urandom_range(0, 28));
    else if (pick < 7) cp = single_line_glyph($urandom_range(0, 10));
    else if (pick < 9) cp = BOX_FIRST + 21'($urandom_range(0, 127));
    else cp = 21'($urandom);
    offer_glyph(cp, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)), allow_gap);
  endtask

  // Stop offering and wait until every predicted rectangle has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rects_pending != 0);
  endtask

  // Write the cell geometry, and optionally poke the unused index.
  task automatic setup_cell(input logic [7:0] w, input logic [7:0] h, input logic [7:0] t,
                            input bit poke_unused);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_CELL_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_CELL_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_index_i <= REG_LINE_THICKNESS;
    cfg_data_i  <= t;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_index_i <= REG_UNUSED;
      cfg_data_i  <= 8'($urandom_range(0, 255));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_cell_setup();
    bit poke;
    poke = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 7))
      0:       setup_cell(8'd1, 8'd1, 8'd1, poke);
      1:       setup_cell(8'd64, 8'd128, 8'd16, poke);
      2:       setup_cell(8'd0, 8'd0, 8'd0, poke);
      3:       setup_cell(8'hFF, 8'hFF, 8'hFF, poke);
      4:       setup_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), poke);
      default: setup_cell(8'($urandom_range(1, 64)), 8'($urandom_range(1, 128)),
                          8'($urandom_range(1, 16)), poke);
    endcase
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_CELL_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: corner glyphs, extremes of position, unknown points.
    offer_glyph(21'h02500, 8'd0, 14'd0, 1'b1);
    offer_glyph(21'h0256C, 8'd255, 14'd16383, 1'b1);
    offer_glyph(21'h0255B, 8'd3, 14'd100, 1'b1);
    offer_glyph(21'h02502, 8'd17, 14'd5000, 1'b1);
    offer_glyph(21'h02551, 8'd128, 14'd8192, 1'b1);
    offer_glyph(21'h00000, 8'd0, 14'd0, 1'b1);
    offer_glyph(21'h1FFFFF, 8'd255, 14'd16383, 1'b1);
    offer_glyph(21'h02501, 8'd9, 14'd33, 1'b1);
    offer_glyph(21'h10FFFF, 8'd200, 14'd1234, 1'b1);
    offer_glyph(21'h0256D, 8'd1, 14'd1, 1'b1);

    // All register bits set, above the stated ranges.
    wait_for_drain();
    setup_cell(8'hFF, 8'hFF, 8'hFF, 1'b1);
    offer_glyph(21'h0256C, 8'd255, 14'd16383, 1'b1);
    offer_glyph(21'h02554, 8'd0, 14'd0, 1'b1);
    offer_glyph(21'h0255A, 8'd77, 14'd9999, 1'b1);

    // Zero width, height and thickness.
    wait_for_drain();
    setup_cell(8'd0, 8'd0, 8'd0, 1'b0);
    offer_glyph(21'h0256C, 8'd100, 14'd50, 1'b1);
    offer_glyph(21'h02560, 8'd0, 14'd0, 1'b1);
    offer_glyph(21'h02500, 8'd255, 14'd16383, 1'b1);

    // Smallest legal geometry, then the largest.
    wait_for_drain();
    setup_cell(8'd1, 8'd1, 8'd1, 1'b0);
    offer_glyph(21'h0256C, 8'd0, 14'd0, 1'b1);
    offer_glyph(21'h02557, 8'd255, 14'd16383, 1'b1);
    wait_for_drain();
    setup_cell(8'd64, 8'd128, 8'd16, 1'b0);
    offer_glyph(21'h0256C, 8'd255, 14'd16383, 1'b1);
    offer_glyph(21'h02563, 8'd31, 14'd700, 1'b1);

    // A write to the unused index must leave the geometry alone.
    wait_for_drain();
    setup_cell(8'd64, 8'd128, 8'd16, 1'b1);
    offer_glyph(21'h02566, 8'd12, 14'd3000, 1'b1);

    // Random phases, each under a fresh geometry; the last one without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_drain();
      pick_cell_setup();
      calm = (phase == PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Stall the sink for a long stretch while requests keep coming.
        if (phase == 3 && n == 10) hold_output = 1'b1;
        offer_random_glyph(!(phase == 3 && n >= 10 && n < 22));
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0 && rects_pending == 0) begin
      $display("PASS box_drawing_glyph_rectangles_top");
    end else begin
      $display("FAIL box_drawing_glyph_rectangles_top");
    end
    $finish;
  end

endmodule
